// File: sv/apngfc_pkg.sv
// Shared types, codes and defaults for the frame compositor.
package apngfc_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    typedef enum logic [1:0] {
        OP_COMPOSE = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_READ    = 2'd2,
        OP_SPARE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_CANVAS_WIDTH  = 3'd0,
        REG_CANVAS_HEIGHT = 3'd1,
        REG_FRAME_LEFT    = 3'd2,
        REG_FRAME_TOP     = 3'd3,
        REG_BLEND_MODE    = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        op_t         op;
        logic        oor;
        logic [15:0] idx;
        pixel_t      src;
    } meta_t;

endpackage

// File: sv/apngfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module apngfc_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/apng_frame_compositor_unit.sv
// Top level of the frame compositor: canvas store with blend pipeline.
//
// Pixel transactions enter on the s_ group: s_tuser carries the operation
// (compose, clear, read), s_tdata the frame coordinates and source RGBA.
// Every transaction yields one transaction on the m_ group: linear canvas
// index and resulting RGBA in m_tdata, out-of-canvas flag in m_tuser.
// Registers (canvas size, frame position, blend mode) are written through
// the cfg_ channel, always ready; the user must write them only while no pixel
// is in flight, as the block does not enforce it. One transaction is taken
// per cycle; a transaction whose pixel index matches a write still in the
// six-stage blend pipeline waits at the issue stage until that write has
// reached the canvas RAM, since the read-modify-write loop runs through the
// RAM read port, multipliers and a four-stage divider.
// Reset clears the pipeline valid bits and loads canvas 256 x 256, offset 0,
// overwrite mode; canvas contents are undefined until written.
// When m_tready is low with m_tvalid high the back pipeline holds, the front
// stages fill and s_tready drops; nothing is lost or repeated.
module apng_frame_compositor_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // col, row, src_red, src_green, src_blue, src_alpha
    input  logic [1:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // canvas_index, out_red, out_green, out_blue, out_alpha
    output logic [0:0]  m_tuser,   // out_of_range
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int MAX_WIDTH  = apngfc_pkg::DEF_MAX_WIDTH;
    localparam int MAX_HEIGHT = apngfc_pkg::DEF_MAX_HEIGHT;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WCAP   = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
    localparam int HCAP   = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
    localparam int NB     = 6;
    localparam int ND     = 4;

    function automatic logic is_write(apngfc_pkg::meta_t m);
        is_write = !m.oor && (m.op == apngfc_pkg::OP_COMPOSE || m.op == apngfc_pkg::OP_CLEAR);
    endfunction

    function automatic logic [24:0] div_step(logic [23:0] rem, logic [23:0] dsh);
        div_step = (rem >= dsh) ? {1'b1, rem - dsh} : {1'b0, rem};
    endfunction

    // configuration
    logic [8:0] canvas_width_reg;
    logic [8:0] canvas_height_reg;
    logic [7:0] frame_left_reg;
    logic [7:0] frame_top_reg;
    logic       blend_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= 9'd256;
            canvas_height_reg <= 9'd256;
            frame_left_reg    <= 8'd0;
            frame_top_reg     <= 8'd0;
            blend_mode_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                apngfc_pkg::REG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_data;
                apngfc_pkg::REG_CANVAS_HEIGHT: canvas_height_reg <= cfg_data;
                apngfc_pkg::REG_FRAME_LEFT:    frame_left_reg    <= cfg_data[7:0];
                apngfc_pkg::REG_FRAME_TOP:     frame_top_reg     <= cfg_data[7:0];
                apngfc_pkg::REG_BLEND_MODE:    blend_mode_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [8:0] width_sat;
    logic [8:0] height_sat;
    assign width_sat  = (32'(canvas_width_reg) > WCAP) ? 9'(WCAP) : canvas_width_reg;
    assign height_sat = (32'(canvas_height_reg) > HCAP) ? 9'(HCAP) : canvas_height_reg;

    // handshake / flow
    logic m_valid_reg;
    logic adv;
    logic hazard;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_move, s2_move, s3_move;
    logic [NB-1:0] bk_valid_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s3_move  = s3_valid_reg && adv && !hazard;
    assign s2_move  = s2_valid_reg && (!s3_valid_reg || s3_move);
    assign s1_move  = s1_valid_reg && (!s2_valid_reg || s2_move);
    assign s_tready = !s1_valid_reg || s1_move;

    // stage 1: input register
    apngfc_pkg::op_t    s1_op_reg;
    logic [7:0]         s1_col_reg;
    logic [7:0]         s1_row_reg;
    apngfc_pkg::pixel_t s1_src_reg;

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_op_reg  <= apngfc_pkg::op_t'(s_tuser);
            s1_col_reg <= s_tdata[7:0];
            s1_row_reg <= s_tdata[15:8];
            s1_src_reg <= {s_tdata[47:40], s_tdata[39:32], s_tdata[31:24], s_tdata[23:16]};
        end
    end

    logic       s1_offset;
    logic [8:0] s1_x, s1_y;
    assign s1_offset = (s1_op_reg == apngfc_pkg::OP_COMPOSE) || (s1_op_reg == apngfc_pkg::OP_CLEAR);
    assign s1_x = {1'b0, s1_col_reg} + (s1_offset ? {1'b0, frame_left_reg} : 9'd0);
    assign s1_y = {1'b0, s1_row_reg} + (s1_offset ? {1'b0, frame_top_reg} : 9'd0);

    // stage 2: index multiply
    apngfc_pkg::op_t    s2_op_reg;
    logic [8:0]         s2_x_reg, s2_y_reg, s2_w_reg;
    logic               s2_oor_reg;
    apngfc_pkg::pixel_t s2_src_reg;

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_op_reg  <= s1_op_reg;
            s2_x_reg   <= s1_x;
            s2_y_reg   <= s1_y;
            s2_w_reg   <= width_sat;
            s2_oor_reg <= (s1_x >= width_sat) || (s1_y >= height_sat);
            s2_src_reg <= s1_src_reg;
        end
    end

    logic [17:0] s2_prod;
    logic [17:0] s2_sum;
    assign s2_prod = s2_y_reg * s2_w_reg;
    assign s2_sum  = s2_prod + {9'd0, s2_x_reg};

    // stage 3: issue to canvas RAM
    apngfc_pkg::meta_t s3_meta_reg;

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            s3_meta_reg.op  <= s2_op_reg;
            s3_meta_reg.oor <= s2_oor_reg;
            s3_meta_reg.idx <= s2_oor_reg ? 16'd0 : s2_sum[15:0];
            s3_meta_reg.src <= s2_src_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            bk_valid_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= (s_tvalid && s_tready) || (s1_valid_reg && !s1_move);
            s2_valid_reg <= s1_move || (s2_valid_reg && !s2_move);
            s3_valid_reg <= s2_move || (s3_valid_reg && !s3_move);
            if (adv)
            begin
                bk_valid_reg <= {bk_valid_reg[NB-2:0], s3_move};
                m_valid_reg  <= bk_valid_reg[NB-1];
            end
        end
    end

    // back pipeline
    apngfc_pkg::meta_t  bk_meta_reg [NB];
    apngfc_pkg::pixel_t bk_dst_reg  [1:NB-1];

    always_comb
    begin
        hazard = 1'b0;
        for (int k = 0; k < NB; k++)
        begin
            if (bk_valid_reg[k] && is_write(bk_meta_reg[k])
                && bk_meta_reg[k].idx == s3_meta_reg.idx)
            begin
                hazard = 1'b1;
            end
        end
    end

    logic               ram_we;
    apngfc_pkg::pixel_t ram_rdata;
    apngfc_pkg::pixel_t result;

    assign ram_we = adv && bk_valid_reg[NB-1] && is_write(bk_meta_reg[NB-1]);

    apngfc_ram #(
        .WIDTH  (32),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_canvas (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(bk_meta_reg[NB-1].idx)),
        .wdata (result),
        .re    (s3_move),
        .raddr (ADDR_W'(s3_meta_reg.idx)),
        .rdata (ram_rdata)
    );

    // bk0: products
    logic [15:0] b0_ps [3];
    logic [15:0] b0_pd [3];
    logic [15:0] b0_dainv;
    logic [15:0] b0_sa255;
    logic [7:0]  b0_sc [3];
    logic [7:0]  b0_dc [3];
    logic [7:0]  b0_sa;

    assign b0_sa = bk_meta_reg[0].src.alpha;
    assign b0_sc = '{bk_meta_reg[0].src.red, bk_meta_reg[0].src.green, bk_meta_reg[0].src.blue};
    assign b0_dc = '{ram_rdata.red, ram_rdata.green, ram_rdata.blue};

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            b0_ps[c] = b0_sc[c] * b0_sa;
            b0_pd[c] = b0_dc[c] * ram_rdata.alpha;
        end
        b0_dainv = ram_rdata.alpha * (8'd255 - b0_sa);
        b0_sa255 = {b0_sa, 8'd0} - {8'd0, b0_sa};
    end

    // bk1: numerators and alpha estimate
    logic [15:0] b1_ps_reg [3];
    logic [15:0] b1_pd_reg [3];
    logic [15:0] b1_dainv_reg;
    logic [15:0] b1_sa255_reg;

    logic [15:0] b1_num;
    logic [23:0] b1_numer [3];
    logic [23:0] b1_num257;
    logic [7:0]  b1_sainv;

    assign b1_sainv  = 8'd255 - bk_meta_reg[1].src.alpha;
    assign b1_num    = b1_sa255_reg + b1_dainv_reg;
    assign b1_num257 = {b1_num, 8'd0} + {8'd0, b1_num};

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            b1_numer[c] = ({b1_ps_reg[c], 8'd0} - {8'd0, b1_ps_reg[c]})
                        + (24'(b1_pd_reg[c]) * 24'(b1_sainv));
        end
    end

    // bk2..bk5: divider, two quotient bits per stage
    logic [23:0] dv_rem_reg [ND][3];
    logic [7:0]  dv_q_reg   [ND][3];
    logic [15:0] dv_num_reg [ND];
    logic [7:0]  dv_aq_reg  [ND];
    logic [23:0] dv_rem_nx  [ND][3];
    logic [7:0]  dv_q_nx    [ND][3];
    logic [7:0]  aq_fix;
    logic [15:0] aq_r;

    assign aq_r   = dv_num_reg[0] - ({dv_aq_reg[0], 8'd0} - {8'd0, dv_aq_reg[0]});
    assign aq_fix = (aq_r >= 16'd255) ? dv_aq_reg[0] + 8'd1 : dv_aq_reg[0];

    for (genvar j = 0; j < ND; j++)
    begin : g_div
        for (genvar c = 0; c < 3; c++)
        begin : g_ch
            logic [24:0] hi, lo;
            always_comb
            begin
                hi = div_step(dv_rem_reg[j][c], 24'(dv_num_reg[j]) << (7 - 2 * j));
                lo = div_step(hi[23:0], 24'(dv_num_reg[j]) << (6 - 2 * j));
                dv_rem_nx[j][c] = lo[23:0];
                dv_q_nx[j][c] = dv_q_reg[j][c];
                dv_q_nx[j][c][7 - 2 * j] = hi[24];
                dv_q_nx[j][c][6 - 2 * j] = lo[24];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bk_meta_reg[0] <= s3_meta_reg;
            for (int k = 1; k < NB; k++)
            begin
                bk_meta_reg[k] <= bk_meta_reg[k-1];
            end
            bk_dst_reg[1] <= ram_rdata;
            for (int k = 2; k < NB; k++)
            begin
                bk_dst_reg[k] <= bk_dst_reg[k-1];
            end
            b1_ps_reg    <= b0_ps;
            b1_pd_reg    <= b0_pd;
            b1_dainv_reg <= b0_dainv;
            b1_sa255_reg <= b0_sa255;
            for (int c = 0; c < 3; c++)
            begin
                dv_rem_reg[0][c] <= b1_numer[c];
                dv_q_reg[0][c]   <= 8'd0;
            end
            dv_num_reg[0] <= b1_num;
            dv_aq_reg[0]  <= b1_num257[23:16];
            dv_aq_reg[1]  <= aq_fix;
            for (int j = 1; j < ND; j++)
            begin
                dv_rem_reg[j] <= dv_rem_nx[j-1];
                dv_q_reg[j]   <= dv_q_nx[j-1];
                dv_num_reg[j] <= dv_num_reg[j-1];
            end
            for (int j = 2; j < ND; j++)
            begin
                dv_aq_reg[j] <= dv_aq_reg[j-1];
            end
        end
    end

    // result select at bk5
    apngfc_pkg::meta_t fin;
    assign fin = bk_meta_reg[NB-1];

    always_comb
    begin
        case (fin.op)
            apngfc_pkg::OP_COMPOSE:
            begin
                if (!blend_mode_reg)
                begin
                    result = fin.src;
                end
                else if (dv_num_reg[ND-1] == 16'd0)
                begin
                    result = '0;
                end
                else
                begin
                    result = {dv_aq_reg[ND-1], dv_q_nx[ND-1][2], dv_q_nx[ND-1][1],
                              dv_q_nx[ND-1][0]};
                end
            end
            apngfc_pkg::OP_CLEAR: result = '0;
            default:              result = bk_dst_reg[NB-1];
        endcase
        if (fin.oor)
        begin
            result = '0;
        end
    end

    // output register
    apngfc_pkg::pixel_t m_pix_reg;
    logic [15:0]        m_idx_reg;
    logic               m_oor_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_pix_reg <= result;
            m_idx_reg <= fin.idx;
            m_oor_reg <= fin.oor;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_pix_reg.alpha, m_pix_reg.blue, m_pix_reg.green, m_pix_reg.red,
                       m_idx_reg};
    assign m_tuser  = m_oor_reg;

`ifndef SYNTHESIS
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && s3_move |-> ADDR_W'(fin.idx) != ADDR_W'(s3_meta_reg.idx))
        else $error("canvas read issued against a pending write");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && !m_tready |=> $stable(bk_valid_reg))
        else $error("back pipeline moved during output stall");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_oor_reg |-> m_tdata == 48'd0)
        else $error("out-of-canvas transaction carries data");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> s1_valid_reg && s2_valid_reg && s3_valid_reg)
        else $error("input stalled with room in front stages");
`endif

endmodule

// File: verif/apngfc_checker.sv
// Checker for the frame compositor: canvas predictor and result scoreboard.
module apngfc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CV_DEPTH = apngfc_pkg::DEF_MAX_WIDTH * apngfc_pkg::DEF_MAX_HEIGHT;

    typedef struct packed {
        logic               oor;
        logic [15:0]        idx;
        apngfc_pkg::pixel_t pix;
    } comp_result_t;

    apngfc_pkg::pixel_t canvas_mem [CV_DEPTH];
    comp_result_t       result_q [$];
    logic [8:0]         cv_width;
    logic [8:0]         cv_height;
    logic [7:0]         fr_left;
    logic [7:0]         fr_top;
    logic               alpha_blend;
    int                 err_cnt = 0;

    function automatic apngfc_pkg::pixel_t blend_over(apngfc_pkg::pixel_t s,
                                                      apngfc_pkg::pixel_t d);
        int unsigned        sa;
        int unsigned        da;
        int unsigned        num;
        apngfc_pkg::pixel_t r;
        sa  = s.alpha;
        da  = d.alpha;
        num = sa * 255 + da * (255 - sa);
        if (num == 0)
            return '0;
        r.red   = 8'((s.red   * sa * 255 + d.red   * da * (255 - sa)) / num);
        r.green = 8'((s.green * sa * 255 + d.green * da * (255 - sa)) / num);
        r.blue  = 8'((s.blue  * sa * 255 + d.blue  * da * (255 - sa)) / num);
        r.alpha = 8'(num / 255);
        return r;
    endfunction

    function automatic comp_result_t composite_pixel(apngfc_pkg::op_t op, logic [7:0] col,
                                                     logic [7:0] row,
                                                     apngfc_pkg::pixel_t src);
        int unsigned  x;
        int unsigned  y;
        int unsigned  w;
        int unsigned  h;
        comp_result_t r;
        x = col;
        y = row;
        w = (cv_width > apngfc_pkg::DEF_MAX_WIDTH) ? apngfc_pkg::DEF_MAX_WIDTH : cv_width;
        h = (cv_height > apngfc_pkg::DEF_MAX_HEIGHT) ? apngfc_pkg::DEF_MAX_HEIGHT : cv_height;
        r = '0;
        if (op == apngfc_pkg::OP_COMPOSE || op == apngfc_pkg::OP_CLEAR)
        begin
            x += fr_left;
            y += fr_top;
        end
        if (x >= w || y >= h)
        begin
            r.oor = 1'b1;
            return r;
        end
        r.idx = 16'(y * w + x);
        case (op)
            apngfc_pkg::OP_COMPOSE:
            begin
                r.pix = alpha_blend ? blend_over(src, canvas_mem[r.idx]) : src;
                canvas_mem[r.idx] = r.pix;
            end
            apngfc_pkg::OP_CLEAR:
                canvas_mem[r.idx] = '0;
            default:
                r.pix = canvas_mem[r.idx];
        endcase
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        err_cnt++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        comp_result_t e;
        comp_result_t g;
        if (!rst_n)
        begin
            cv_width    <= 9'd256;
            cv_height   <= 9'd256;
            fr_left     <= '0;
            fr_top      <= '0;
            alpha_blend <= 1'b0;
            result_q.delete();
            foreach (canvas_mem[i])
                canvas_mem[i] = '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (apngfc_pkg::reg_index_t'(cfg_index))
                    apngfc_pkg::REG_CANVAS_WIDTH:  cv_width    <= cfg_data;
                    apngfc_pkg::REG_CANVAS_HEIGHT: cv_height   <= cfg_data;
                    apngfc_pkg::REG_FRAME_LEFT:    fr_left     <= cfg_data[7:0];
                    apngfc_pkg::REG_FRAME_TOP:     fr_top      <= cfg_data[7:0];
                    apngfc_pkg::REG_BLEND_MODE:    alpha_blend <= cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                result_q.insert(result_q.size(),
                                composite_pixel(apngfc_pkg::op_t'(s_tuser), s_tdata[7:0],
                                                s_tdata[15:8],
                                                apngfc_pkg::pixel_t'(s_tdata[47:16])));
            if (m_tvalid && m_tready)
            begin
                g = {m_tuser[0], m_tdata[15:0], apngfc_pkg::pixel_t'(m_tdata[47:16])};
                if (result_q.size() == 0)
                    report("unexpected transaction", int'(g.idx), 0);
                else
                begin
                    e = result_q.pop_front();
                    if (g.idx != e.idx)
                        report("canvas_index", int'(g.idx), int'(e.idx));
                    if (g.pix.red != e.pix.red)
                        report("out_red", int'(g.pix.red), int'(e.pix.red));
                    if (g.pix.green != e.pix.green)
                        report("out_green", int'(g.pix.green), int'(e.pix.green));
                    if (g.pix.blue != e.pix.blue)
                        report("out_blue", int'(g.pix.blue), int'(e.pix.blue));
                    if (g.pix.alpha != e.pix.alpha)
                        report("out_alpha", int'(g.pix.alpha), int'(e.pix.alpha));
                    if (g.oor != e.oor)
                        report("out_of_range", int'(g.oor), int'(e.oor));
                end
            end
        end
        pending <= result_q.size();
        errors  <= err_cnt;
    end

endmodule

// File: verif/tb_top.sv
// Testbench top for the frame compositor: stimulus, handshakes and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN      = 14;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [8:0]  cfg_data;
    int          errors;
    int          pending;
    int          idle_cycles;
    int          burst_left;

    bit          written [65536];
    int unsigned cur_w;
    int unsigned cur_h;
    int unsigned cur_left;
    int unsigned cur_top;
    bit          cur_blend;

    apng_frame_compositor_unit u_top (.*);

    apngfc_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = 1'b1;
            #4 clk = 1'b0;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // receiver: changing stall patterns, one long hold-off to back up the pipeline
    initial
    begin
        int rcnt;
        int mode;
        rcnt     = 0;
        mode     = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rcnt++;
            if (rcnt % 150 == 0)
                mode = $urandom_range(0, 2);
            if (rcnt >= 600 && rcnt < 1000)
                m_tready <= 1'b0;
            else if (mode == 0)
                m_tready <= 1'b1;
            else if (mode == 1)
                m_tready <= (rcnt % 5) > 1;
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic write_reg(apngfc_pkg::reg_index_t ri, int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= val[8:0];
        do @(posedge clk); while (!cfg_ready);
        case (ri)
            apngfc_pkg::REG_CANVAS_WIDTH:  cur_w     = (val > 256) ? 256 : val;
            apngfc_pkg::REG_CANVAS_HEIGHT: cur_h     = (val > 256) ? 256 : val;
            apngfc_pkg::REG_FRAME_LEFT:    cur_left  = 32'(val[7:0]);
            apngfc_pkg::REG_FRAME_TOP:     cur_top   = 32'(val[7:0]);
            apngfc_pkg::REG_BLEND_MODE:    cur_blend = val[0];
            default: ;
        endcase
    endtask

    task automatic set_canvas(int unsigned w, int unsigned h, int unsigned l, int unsigned t,
                              bit b);
        repeat (DRAIN) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        write_reg(apngfc_pkg::REG_CANVAS_WIDTH, w);
        write_reg(apngfc_pkg::REG_CANVAS_HEIGHT, h);
        write_reg(apngfc_pkg::REG_FRAME_LEFT, l);
        write_reg(apngfc_pkg::REG_FRAME_TOP, t);
        write_reg(apngfc_pkg::REG_BLEND_MODE, 32'(b));
        cfg_valid <= 1'b0;
    endtask

    // keeps reads and blends off entries never written, then sends one transaction
    task automatic send_pixel(apngfc_pkg::op_t op, logic [7:0] col, logic [7:0] row,
                              apngfc_pkg::pixel_t px);
        int unsigned x;
        int unsigned y;
        int unsigned idx;
        int          gap;
        x = col;
        y = row;
        if (op == apngfc_pkg::OP_COMPOSE || op == apngfc_pkg::OP_CLEAR)
        begin
            x += cur_left;
            y += cur_top;
        end
        if (x < cur_w && y < cur_h)
        begin
            idx = y * cur_w + x;
            if (!written[idx] && (op == apngfc_pkg::OP_READ || op == apngfc_pkg::OP_SPARE ||
                                  (op == apngfc_pkg::OP_COMPOSE && cur_blend)))
                op = apngfc_pkg::OP_CLEAR;
        end
        // the clear lands at the offset position, so mark that one
        x = col;
        y = row;
        if (op == apngfc_pkg::OP_COMPOSE || op == apngfc_pkg::OP_CLEAR)
        begin
            x += cur_left;
            y += cur_top;
            if (x < cur_w && y < cur_h)
                written[y * cur_w + x] = 1'b1;
        end
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {px, row, col};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic random_pixels(int n);
        int                 k;
        apngfc_pkg::op_t    op;
        int unsigned        cx;
        int unsigned        cy;
        logic [7:0]         col;
        logic [7:0]         row;
        apngfc_pkg::pixel_t px;
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 19))
                0, 1:   op = apngfc_pkg::OP_CLEAR;
                2:      op = apngfc_pkg::OP_SPARE;
                3, 4, 5, 6, 7, 8, 9: op = apngfc_pkg::OP_READ;
                default: op = apngfc_pkg::OP_COMPOSE;
            endcase
            px = $urandom;
            if ($urandom_range(0, 3) == 0)
                px.alpha = $urandom_range(0, 1) ? 8'd0 : 8'd255;
            if ($urandom_range(0, 4) == 0 || cur_w == 0 || cur_h == 0)
            begin
                col = 8'($urandom);
                row = 8'($urandom);
            end
            else
            begin
                cx = $urandom_range(0, ((cur_w > 16) ? 16 : cur_w) - 1);
                cy = $urandom_range(0, ((cur_h > 16) ? 16 : cur_h) - 1);
                if ($urandom_range(0, 7) == 0)
                begin
                    cx = cur_w - 1;
                    cy = cur_h - 1;
                end
                if (op == apngfc_pkg::OP_COMPOSE || op == apngfc_pkg::OP_CLEAR)
                begin
                    col = (cx >= cur_left) ? 8'(cx - cur_left) : 8'($urandom);
                    row = (cy >= cur_top) ? 8'(cy - cur_top) : 8'($urandom);
                end
                else
                begin
                    col = 8'(cx);
                    row = 8'(cy);
                end
            end
            send_pixel(op, col, row, px);
        end
    endtask

    initial
    begin
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = apngfc_pkg::OP_READ;
        cfg_valid  = 1'b0;
        cfg_index  = apngfc_pkg::REG_CANVAS_WIDTH;
        cfg_data   = '0;
        cur_w      = 256;
        cur_h      = 256;
        cur_left   = 0;
        cur_top    = 0;
        cur_blend  = 1'b0;
        burst_left = 0;
        @(posedge rst_n);
        @(posedge clk);

        send_pixel(apngfc_pkg::OP_COMPOSE, 8'd0, 8'd0, 32'h0000_0000);
        send_pixel(apngfc_pkg::OP_COMPOSE, 8'd255, 8'd255, 32'hFFFF_FFFF);
        send_pixel(apngfc_pkg::OP_READ, 8'd0, 8'd0, 32'hFFFF_FFFF);
        send_pixel(apngfc_pkg::OP_READ, 8'd255, 8'd255, 32'h0);
        send_pixel(apngfc_pkg::OP_COMPOSE, 8'd1, 8'd0, 32'h80C0_4020);
        send_pixel(apngfc_pkg::OP_SPARE, 8'd1, 8'd0, 32'h0);
        send_pixel(apngfc_pkg::OP_CLEAR, 8'd255, 8'd255, 32'h1234_5678);
        send_pixel(apngfc_pkg::OP_READ, 8'd255, 8'd255, 32'h0);
        s_tvalid <= 1'b0;

        // offsets at the top end: all but the first frame pixel falls off the canvas
        set_canvas(256, 256, 255, 255, 1);
        send_pixel(apngfc_pkg::OP_COMPOSE, 8'd0, 8'd0, 32'h00FF_FFFF);
        send_pixel(apngfc_pkg::OP_COMPOSE, 8'd0, 8'd0, 32'h7F10_2030);
        send_pixel(apngfc_pkg::OP_COMPOSE, 8'd0, 8'd0, 32'hFF01_0203);
        send_pixel(apngfc_pkg::OP_COMPOSE, 8'd1, 8'd0, 32'hFFFF_FFFF);
        send_pixel(apngfc_pkg::OP_CLEAR, 8'd0, 8'd1, 32'h0);
        send_pixel(apngfc_pkg::OP_READ, 8'd255, 8'd255, 32'h0);
        s_tvalid <= 1'b0;

        set_canvas(8, 8, 2, 3, 1);
        random_pixels(60);
        s_tvalid <= 1'b0;
        set_canvas(16, 4, 0, 0, 0);
        random_pixels(40);
        s_tvalid <= 1'b0;
        set_canvas(1, 1, 0, 0, 1);
        random_pixels(25);
        s_tvalid <= 1'b0;
        set_canvas(256, 1, 10, 0, 1);
        random_pixels(45);
        s_tvalid <= 1'b0;
        set_canvas(1, 256, 0, 0, 0);
        random_pixels(35);
        s_tvalid <= 1'b0;
        set_canvas(0, 5, 0, 0, 0);
        random_pixels(15);
        s_tvalid <= 1'b0;
        set_canvas(511, 300, 0, 0, 1);
        random_pixels(60);
        s_tvalid <= 1'b0;
        set_canvas(5, 5, 255, 255, 1);
        random_pixels(20);
        s_tvalid <= 1'b0;
        set_canvas(12, 10, 3, 1, 1);
        random_pixels(80);
        s_tvalid <= 1'b0;
        set_canvas(4, 4, 0, 0, 1);
        random_pixels(70);
        s_tvalid <= 1'b0;
        set_canvas(200, 0, 1, 1, 0);
        random_pixels(15);
        s_tvalid <= 1'b0;

        repeat (DRAIN) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
